[src/htdp_pkg.sv]
// ----------------------------------------------------------------------------
// htdp_pkg
// Shared widths, item types, control/status structs and hash helpers for the
// hashed table lookup core.
// ----------------------------------------------------------------------------
package htdp_pkg;

	localparam int unsigned DEFAULT_TABLE_SLOTS = 256;

	localparam int unsigned KEY_W     = 64;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned SLOT_IN_W = 8;
	localparam int unsigned HASH_W    = 32;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// one-at-a-time shift amounts
	localparam int unsigned OAAT_MIX_SHL = 10;
	localparam int unsigned OAAT_MIX_SHR = 6;
	localparam int unsigned OAAT_FIN_SHL_A = 3;
	localparam int unsigned OAAT_FIN_SHR = 11;
	localparam int unsigned OAAT_FIN_SHL_B = 15;

	typedef struct packed {
		logic                 op;
		logic [KEY_W-1:0]     key;
		logic [SLOT_IN_W-1:0] slot_in;
		logic [LEN_W-1:0]     length_in;
		logic [DATA_W-1:0]    data_low_in;
		logic [DATA_W-1:0]    data_high_in;
	} in_item_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_IN_W-1:0] slot_out;
		logic [LEN_W-1:0]     length_out;
		logic [DATA_W-1:0]    data_low_out;
		logic [DATA_W-1:0]    data_high_out;
	} out_item_t;

	typedef enum logic [1:0] {
		RES_WRITE,
		RES_HIT,
		RES_MISS
	} res_kind_t;

	typedef struct packed {
		logic      clr_wr;
		logic      load_item;
		logic      mem_wr;
		logic      hash_step;
		logic      hash_final;
		logic      mod_start;
		logic      mod_sel;     // 0: reduce by table size, 1: by table size minus two
		logic      mod_x_sum;   // reduce the running probe sum instead of the hash
		logic      cap_cur;
		logic      cap_step;
		logic      probe_rd;
		logic      out_load;
		res_kind_t res_kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic mod_done;
		logic key_empty;
		logic key_match;
		logic probes_done;
	} dp_status_t;

	function automatic logic [HASH_W-1:0] oaat_mix(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] t;
		t = h + HASH_W'(b);
		t = t + (t << OAAT_MIX_SHL);
		t = t ^ (t >> OAAT_MIX_SHR);
		return t;
	endfunction

	function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] t;
		t = h + (h << OAAT_FIN_SHL_A);
		t = t ^ (t >> OAAT_FIN_SHR);
		t = t + (t << OAAT_FIN_SHL_B);
		return t;
	endfunction

endpackage

[src/htdp_chan_if.sv]
// ----------------------------------------------------------------------------
// htdp_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface htdp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/hashed_table_lookup_double_probe_core.sv]
// ----------------------------------------------------------------------------
// hashed_table_lookup_double_probe_core
// Keyed table with one-at-a-time hashing and double-hashing probe lookup.
// ----------------------------------------------------------------------------
// After reset the core sweeps the key memory to empty, one slot per cycle;
// item.ready stays low during that sweep. One item is worked at a time. A
// write goes from the transfer to the table write and then to loading the
// result. A lookup hashes the key one byte per cycle, finalizes the hash,
// reduces the hash for the first slot and the step through the three-stage
// remainder unit, then runs the probes (registered memory read, compare, and
// a wait on the remainder unit for the next slot), the last probe needing
// only the read and compare, and then loads the result. A finished result
// waits in the output register while the next item is taken in.
module hashed_table_lookup_double_probe_core #(
	parameter int unsigned TABLE_SLOTS = htdp_pkg::DEFAULT_TABLE_SLOTS
) (
	input logic        clk,
	input logic        arst_n,
	htdp_chan_if.sink   item,
	htdp_chan_if.source result
);
	htdp_pkg::ctrl_cmd_t  cmd;
	htdp_pkg::dp_status_t status;

	htdp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_op     (item.payload.op),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.status      (status),
		.cmd         (cmd)
	);

	htdp_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_data  (item.payload),
		.cmd        (cmd),
		.status     (status),
		.result_data(result.payload)
	);

	// one item in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item transfer accepted while busy");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.mem_wr && !item.ready)
		else $error("table write during clearing sweep");

	a_mod_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		status.mod_done |=> !status.mod_done)
		else $error("remainder unit done held longer than one cycle");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.valid)
		else $error("result loaded but not presented");
endmodule

[src/htdp_modred.sv]
// ----------------------------------------------------------------------------
// htdp_modred
// Three-stage remainder unit: 32-bit value modulo the table size or the
// table size minus two, by reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module htdp_modred #(
	parameter int unsigned TABLE_SLOTS = htdp_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  sel,
	input  logic [htdp_pkg::HASH_W-1:0]           x,
	output logic                                  done,
	output logic [$clog2(TABLE_SLOTS)-1:0]        rem
);
	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
	localparam int unsigned HW = htdp_pkg::HASH_W;
	localparam int unsigned RECIP_W = HW + 1;
	localparam int unsigned PROD_W = HW + RECIP_W;
	localparam logic [HW-1:0] DIV_A = HW'(TABLE_SLOTS);
	localparam logic [HW-1:0] DIV_B = HW'(TABLE_SLOTS - 2);
	localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'((64'd1 << HW) / 64'(TABLE_SLOTS));
	localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'((64'd1 << HW) / 64'(TABLE_SLOTS - 2));

	logic              v_s1, v_s2, v_s3;
	logic              sel_s1, sel_s2;
	logic [HW-1:0]     x_s1, x_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [HW-1:0]     qd_s2;
	logic [SLOT_W-1:0] rem_s3;

	logic [RECIP_W-1:0] recip;
	logic [HW-1:0]      q_est;
	logic [HW-1:0]      div_s1, div_s2;
	logic [HW-1:0]      diff;
	logic [HW-1:0]      rem_full;

	always_comb begin
		recip    = sel ? RECIP_B : RECIP_A;
		q_est    = prod_s1[2*HW-1:HW];
		div_s1   = sel_s1 ? DIV_B : DIV_A;
		div_s2   = sel_s2 ? DIV_B : DIV_A;
		// estimate is low by at most one, so one subtract corrects it
		diff     = x_s2 - qd_s2;
		rem_full = (diff >= div_s2) ? diff - div_s2 : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		sel_s1  <= sel;
		prod_s1 <= PROD_W'(x) * PROD_W'(recip);
		x_s2    <= x_s1;
		sel_s2  <= sel_s1;
		qd_s2   <= q_est * div_s1;
		rem_s3  <= SLOT_W'(rem_full);
	end

	assign done = v_s3;
	assign rem  = rem_s3;
endmodule

[src/htdp_datapath.sv]
// ----------------------------------------------------------------------------
// htdp_datapath
// Key and entry memories, hash register, probe sequencing registers and the
// result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module htdp_datapath #(
	parameter int unsigned TABLE_SLOTS = htdp_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htdp_pkg::in_item_t    item_data,
	input  htdp_pkg::ctrl_cmd_t   cmd,
	output htdp_pkg::dp_status_t  status,
	output htdp_pkg::out_item_t   result_data
);
	localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int unsigned WIDE_W  =
		((SLOT_W > htdp_pkg::SLOT_IN_W) ? SLOT_W : htdp_pkg::SLOT_IN_W) + 1;
	localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned HW      = htdp_pkg::HASH_W;
	localparam int unsigned LEN_W   = htdp_pkg::LEN_W;
	localparam int unsigned DATA_W  = htdp_pkg::DATA_W;
	localparam int unsigned ENTRY_W = LEN_W + 2 * DATA_W;

	logic [htdp_pkg::KEY_W-1:0] key_mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0]         entry_mem [TABLE_SLOTS];

	htdp_pkg::in_item_t         item_q;
	htdp_pkg::out_item_t        out_q;
	logic [HW-1:0]              h_q;
	logic [2:0]                 byte_q;
	logic [SLOT_W-1:0]          cur_q;
	logic [HW-1:0]              step_q;
	logic [HW-1:0]              sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [SLOT_W-1:0]          clr_q;
	logic [htdp_pkg::KEY_W-1:0] key_rd_q;
	logic [ENTRY_W-1:0]         entry_rd_q;

	logic [WIDE_W-1:0] slot_wide;
	logic              in_range;
	logic              tbl_wr;
	logic [SLOT_W-1:0] wr_addr;
	logic [7:0]        key_byte;
	logic [HW-1:0]     mod_x;
	logic              mod_done;
	logic [SLOT_W-1:0] mod_rem;
	logic [HW-1:0]     step_nxt;

	always_comb begin
		slot_wide = WIDE_W'(item_q.slot_in);
		in_range  = slot_wide < WIDE_W'(TABLE_SLOTS);
		wr_addr   = slot_wide[SLOT_W-1:0];
		tbl_wr    = cmd.mem_wr && in_range;
		key_byte  = item_q.key[{byte_q, 3'b000} +: 8];
		mod_x     = cmd.mod_x_sum ? sum_q : h_q;
		step_nxt  = HW'(mod_rem) + HW'(1);
	end

	htdp_modred #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_modred (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mod_start),
		.sel   (cmd.mod_sel),
		.x     (mod_x),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	// memories: one write port, registered read at the current probe slot
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			key_mem[clr_q] <= '0;
		end else if (tbl_wr) begin
			key_mem[wr_addr] <= item_q.key;
		end
		if (cmd.probe_rd) begin
			key_rd_q <= key_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			entry_mem[wr_addr] <= {item_q.length_in, item_q.data_high_in, item_q.data_low_in};
		end
		if (cmd.probe_rd) begin
			entry_rd_q <= entry_mem[cur_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			byte_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (cmd.load_item) begin
				byte_q <= '0;
			end else if (cmd.hash_step) begin
				byte_q <= byte_q + 3'd1;
			end
			if (cmd.cap_step) begin
				cnt_q <= '0;
			end else if (cmd.probe_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item_data;
			h_q    <= '0;
		end else if (cmd.hash_step) begin
			h_q <= htdp_pkg::oaat_mix(h_q, key_byte);
		end else if (cmd.hash_final) begin
			h_q <= htdp_pkg::oaat_final(h_q);
		end
		if (cmd.cap_cur) begin
			cur_q <= mod_rem;
		end
		if (cmd.cap_step) begin
			step_q <= step_nxt;
			sum_q  <= h_q + step_nxt;
		end else if (cmd.probe_rd) begin
			sum_q <= sum_q + step_q;
		end
		if (cmd.out_load) begin
			case (cmd.res_kind)
				htdp_pkg::RES_HIT: begin
					out_q.found         <= 1'b1;
					out_q.slot_out      <= htdp_pkg::SLOT_IN_W'(cur_q);
					out_q.length_out    <= entry_rd_q[ENTRY_W-1 -: LEN_W];
					out_q.data_high_out <= entry_rd_q[2*DATA_W-1:DATA_W];
					out_q.data_low_out  <= entry_rd_q[DATA_W-1:0];
				end
				htdp_pkg::RES_WRITE: begin
					out_q <= {1'b0, item_q.slot_in, {(LEN_W + 2 * DATA_W){1'b0}}};
				end
				default: begin
					out_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		status.clr_last    = clr_q == SLOT_W'(TABLE_SLOTS - 1);
		status.hash_last   = byte_q == 3'd7;
		status.mod_done    = mod_done;
		status.key_empty   = key_rd_q == '0;
		status.key_match   = key_rd_q == item_q.key;
		status.probes_done = cnt_q == CNT_W'(TABLE_SLOTS);
	end

	assign result_data = out_q;
endmodule

[src/htdp_ctrl.sv]
// ----------------------------------------------------------------------------
// htdp_ctrl
// Sequencer for clearing, table writes, hashing and the probe loop; owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module htdp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_op,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  htdp_pkg::dp_status_t status,
	output htdp_pkg::ctrl_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_HASH,
		S_FIN,
		S_CUR,
		S_CUR_W,
		S_STEP,
		S_STEP_W,
		S_READ,
		S_CMP,
		S_WAIT,
		S_DONE
	} state_t;

	state_t              state_q;
	htdp_pkg::res_kind_t res_kind_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign item_ready   = state_q == S_IDLE;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.res_kind = res_kind_q;
		case (state_q)
			S_CLEAR:  cmd.clr_wr     = 1'b1;
			S_IDLE:   cmd.load_item  = item_valid;
			S_WRITE:  cmd.mem_wr     = 1'b1;
			S_HASH:   cmd.hash_step  = 1'b1;
			S_FIN:    cmd.hash_final = 1'b1;
			S_CUR:    cmd.mod_start  = 1'b1;
			S_CUR_W:  cmd.cap_cur    = status.mod_done;
			S_STEP: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel   = 1'b1;
			end
			S_STEP_W: cmd.cap_step   = status.mod_done;
			S_READ: begin
				// read this slot and start reducing the next probe position
				cmd.probe_rd  = 1'b1;
				cmd.mod_start = 1'b1;
				cmd.mod_x_sum = 1'b1;
			end
			S_WAIT:   cmd.cap_cur    = status.mod_done;
			S_DONE:   cmd.out_load   = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_kind_q  <= htdp_pkg::RES_MISS;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= (item_op == htdp_pkg::OP_WRITE) ? S_WRITE : S_HASH;
					end
				end
				S_WRITE: begin
					res_kind_q <= htdp_pkg::RES_WRITE;
					state_q    <= S_DONE;
				end
				S_HASH: begin
					if (status.hash_last) state_q <= S_FIN;
				end
				S_FIN:    state_q <= S_CUR;
				S_CUR:    state_q <= S_CUR_W;
				S_CUR_W: begin
					if (status.mod_done) state_q <= S_STEP;
				end
				S_STEP:   state_q <= S_STEP_W;
				S_STEP_W: begin
					if (status.mod_done) state_q <= S_READ;
				end
				S_READ:   state_q <= S_CMP;
				S_CMP: begin
					if (status.key_empty) begin
						res_kind_q <= htdp_pkg::RES_MISS;
						state_q    <= S_DONE;
					end else if (status.key_match) begin
						res_kind_q <= htdp_pkg::RES_HIT;
						state_q    <= S_DONE;
					end else if (status.probes_done) begin
						res_kind_q <= htdp_pkg::RES_MISS;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (status.mod_done) state_q <= S_READ;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
